// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the integer to digits block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define RTD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RTD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/rtd_pkg.sv =====
// Types, constants and sizes for the integer to digits block.
`default_nettype none

package rtd_pkg;

   localparam int MAX_SYMBOLS  = 16;
   localparam int VALUE_BITS   = 32;
   localparam int SYMBOL_SLOTS = 16;                 // fixed by the two 64-bit symbol registers
   localparam int SYMBOL_W     = 8;
   localparam int COUNT_W      = 5;                  // width of symbol_count
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_INDEX_W  = 2;
   localparam int MAG_BITS     = VALUE_BITS + 1;
   localparam int DIGIT_W      = $clog2(MAX_SYMBOLS);
   localparam int CNT_W        = $clog2(MAG_BITS + 1);
   localparam int STEP_BITS    = 8;                  // quotient bits resolved per divider cycle
   localparam int DIV_STEPS    = (MAG_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int DIV_BITS     = DIV_STEPS * STEP_BITS;
   localparam int STEP_CNT_W   = $clog2(DIV_STEPS);

   localparam logic [SYMBOL_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [SYMBOL_W-1:0] CH_PLUS  = 8'h2B;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SYMBOL_COUNT = 2'd0,
      CSR_SYMBOLS_LOW  = 2'd1,
      CSR_SYMBOLS_HIGH = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SIGN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                start;
      logic [MAG_BITS-1:0] dividend;
      logic [COUNT_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [MAG_BITS-1:0] quotient;
      logic [DIGIT_W-1:0]  remainder;
   } div_rsp_type;

endpackage

`default_nettype wire

// ===== rtl/core/rtd_divider.sv =====
// Iterative divider by a small radix, STEP_BITS quotient bits per cycle.
`default_nettype none

module rtd_divider
   import rtd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);

   logic [DIV_BITS-1:0]   work_ff, work_in;
   logic [DIGIT_W-1:0]    rem_ff, rem_in;
   logic [COUNT_W-1:0]    divisor_ff, divisor_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   // Restoring long division; quotient bits shift in at the bottom of work.
   always_comb begin
      logic [DIV_BITS-1:0] w;
      logic [DIGIT_W-1:0]  r;
      logic [COUNT_W-1:0]  t;
      w          = work_ff;
      r          = rem_ff;
      t          = '0;
      work_in    = work_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (div_req.start) begin
         work_in    = DIV_BITS'(div_req.dividend);
         rem_in     = '0;
         divisor_in = div_req.divisor;
         cnt_in     = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         for (int i = 0; i < STEP_BITS; i++) begin
            t = COUNT_W'({r, w[DIV_BITS-1]});
            w = {w[DIV_BITS-2:0], 1'b0};
            if (t >= divisor_ff) begin
               w[0] = 1'b1;
               r    = DIGIT_W'(t - divisor_ff);
            end else begin
               r    = DIGIT_W'(t);
            end
         end
         work_in = w;
         rem_in  = r;
         cnt_in  = STEP_CNT_W'(cnt_ff + 1'b1);
         if (cnt_ff == STEP_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = work_ff[MAG_BITS-1:0];
   assign div_rsp.remainder = rem_ff;

endmodule

`default_nettype wire

// ===== rtl/core/radix_integer_to_digits.sv =====
// Signed integer to digit symbols in a configured radix: sequencer, digit stack, output register.
//
// Usage:
//   csr_*  : register writes (index 0 symbol_count, 1 symbols_low, 2 symbols_high),
//            always ready; write only while the block is idle.
//   req_*  : one signed value per word; req_ready is high only while the block is idle.
//   rsp_*  : one symbol per word, '-' first for a negative value, digits most
//            significant first, rsp_last on the final symbol of the value.
// An invalid alphabet (fewer than two symbols, too many, a repeat, '+', '-' or a
// zero byte) swallows the value and produces nothing.
// Conversion: each digit costs one pass of the shared divider, digit after digit, and
// then the symbols go out one per cycle while the receiver is ready (D for a value
// with D digits, plus one for the sign). At most 32 digits plus the sign, so at most
// 33 symbols per value.
// The next value is accepted once the last symbol sits in the output register.
// A stalled receiver holds the output register and the sequencer waits on it.
// Reset clears the registers to zero (empty alphabet) and drops any pending output.
`default_nettype none
`include "assert_macros.svh"

module radix_integer_to_digits
   import rtd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   input  wire logic signed [31:0]     req_value,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      logic [SYMBOL_W-1:0]    rsp_symbol,
   output      logic                   rsp_last
);

   logic [COUNT_W-1:0]    symbol_count_ff;
   logic [CSR_DATA_W-1:0] symbols_low_ff;
   logic [CSR_DATA_W-1:0] symbols_high_ff;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  neg_ff, neg_in;
   logic [DIGIT_W-1:0]    stack_ff [MAG_BITS];
   logic [DIGIT_W-1:0]    stack_in [MAG_BITS];
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SYMBOL_W-1:0]   rsp_symbol_ff, rsp_symbol_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [2*CSR_DATA_W-1:0] sym_table;
   logic                    alpha_ok;
   logic [VALUE_BITS-1:0]   raw;
   logic [MAG_BITS-1:0]     mag;
   logic                    slot_free;
   logic                    load;
   div_req_type             div_req;
   div_rsp_type             div_rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         symbol_count_ff <= '0;
         symbols_low_ff  <= '0;
         symbols_high_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_SYMBOL_COUNT: symbol_count_ff <= csr_data[COUNT_W-1:0];
            CSR_SYMBOLS_LOW:  symbols_low_ff  <= csr_data;
            CSR_SYMBOLS_HIGH: symbols_high_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign sym_table = {symbols_high_ff, symbols_low_ff};

   // Pairwise compares are independent; only the reduction is shared.
   always_comb begin
      logic bad;
      bad = 1'b0;
      for (int a = 0; a < SYMBOL_SLOTS; a++) begin
         if (a < int'(symbol_count_ff)) begin
            if (sym_table[a*SYMBOL_W +: SYMBOL_W] == '0 ||
                sym_table[a*SYMBOL_W +: SYMBOL_W] == CH_MINUS ||
                sym_table[a*SYMBOL_W +: SYMBOL_W] == CH_PLUS)
               bad = 1'b1;
            for (int b = a + 1; b < SYMBOL_SLOTS; b++) begin
               if (b < int'(symbol_count_ff) &&
                   sym_table[b*SYMBOL_W +: SYMBOL_W] == sym_table[a*SYMBOL_W +: SYMBOL_W])
                  bad = 1'b1;
            end
         end
      end
      alpha_ok = !bad && symbol_count_ff >= COUNT_W'(2) &&
                 symbol_count_ff <= COUNT_W'(MAX_SYMBOLS);
   end

   // Magnitude one bit wider so the most negative value survives negation.
   assign raw = VALUE_BITS'(req_value);
   assign mag = raw[VALUE_BITS-1] ? MAG_BITS'(-{raw[VALUE_BITS-1], raw})
                                  : MAG_BITS'(raw);

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      neg_in           = neg_ff;
      stack_in         = stack_ff;
      load             = 1'b0;
      rsp_symbol_in    = rsp_symbol_ff;
      rsp_last_in      = rsp_last_ff;
      div_req.start    = 1'b0;
      div_req.dividend = mag;
      div_req.divisor  = symbol_count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && alpha_ok) begin
               div_req.start = 1'b1;
               neg_in        = raw[VALUE_BITS-1];
               count_in      = '0;
               state_in      = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               // push the new digit; digits come out least significant first
               stack_in[0] = div_rsp.remainder;
               for (int i = 1; i < MAG_BITS; i++) stack_in[i] = stack_ff[i-1];
               count_in = CNT_W'(count_ff + 1'b1);
               if (div_rsp.quotient == '0) begin
                  state_in = neg_ff ? ST_SIGN : ST_EMIT;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = div_rsp.quotient;
               end
            end
         end
         ST_SIGN: begin
            if (slot_free) begin
               load          = 1'b1;
               rsp_symbol_in = CH_MINUS;
               rsp_last_in   = 1'b0;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               load          = 1'b1;
               rsp_symbol_in = sym_table[{stack_ff[0], 3'b000} +: SYMBOL_W];
               rsp_last_in   = (count_ff == CNT_W'(1));
               for (int i = 0; i < MAG_BITS - 1; i++) stack_in[i] = stack_ff[i+1];
               stack_in[MAG_BITS-1] = '0;
               count_in = CNT_W'(count_ff - 1'b1);
               if (count_ff == CNT_W'(1)) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff        <= neg_in;
      stack_ff      <= stack_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_last_ff   <= rsp_last_in;
   end

   rtd_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;
   assign rsp_last   = rsp_last_ff;

   `RTD_ASSERT_NEXT(a_bad_alpha_drops, req_valid && req_ready && !alpha_ok, state_ff == ST_IDLE, "invalid alphabet started a conversion")
   `RTD_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= CNT_W'(MAG_BITS), "digit count beyond magnitude width")
   `RTD_ASSERT_SAME(a_emit_nonempty, state_ff == ST_EMIT || state_ff == ST_SIGN, count_ff != '0, "emitting with an empty digit stack")
   `RTD_ASSERT_SAME(a_done_in_divide, div_rsp.done, state_ff == ST_DIVIDE, "divider finished outside the divide phase")

endmodule

`default_nettype wire
